### rtl/assert_macros.svh
// Assertion helpers for the checker file spi_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spi_pkg.sv
package spi_pkg;

    localparam int CoordW  = 32;          // coordinate width, Q16.16
    localparam int OrgW    = 32;          // plane origin register width
    localparam int NrmW    = 16;          // normal component width, Q1.14
    localparam int TolW    = 31;          // tolerance register width
    localparam int NrmFrac = 14;          // fraction bits of the normal
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 32;

    localparam logic [CfgIdxW-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_NRM_X = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_NRM_Y = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_NRM_Z = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_TOL   = 3'd6;

    localparam logic [NrmW-1:0] NrmZReset = 16'sd16384;

    typedef struct packed {
        logic signed [CoordW-1:0] seg_start_x;
        logic signed [CoordW-1:0] seg_start_y;
        logic signed [CoordW-1:0] seg_start_z;
        logic signed [CoordW-1:0] seg_end_x;
        logic signed [CoordW-1:0] seg_end_y;
        logic signed [CoordW-1:0] seg_end_z;
    } t_seg_req;

    typedef struct packed {
        logic                     intersects;
        logic                     crossing;
        logic                     below;
        logic                     above;
        logic                     upwards;
        logic                     downwards;
        logic                     start_touch;
        logic                     end_touch;
        logic                     coincident;
        logic signed [CoordW-1:0] hit_x;
        logic signed [CoordW-1:0] hit_y;
        logic signed [CoordW-1:0] hit_z;
    } t_seg_rsp;

endpackage

### rtl/segment_plane_intersect.sv
// Channel | Direction | Handshake                | Payload
// request | in        | i_in_valid / o_in_ready  | i_in_req  (t_seg_req)
// result  | out       | o_out_valid / i_out_ready| o_out_rsp (t_seg_rsp)
// config  | in        | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// One request per cycle, while o_in_ready is high, enters CoordW + 4 register stages
// (origin subtract, normal multiply, height sum, classify, one interpolation quotient bit
// per stage), then the output register that drives o_out_valid.
// Reset (i_rst_n low, synchronous) empties the pipe and loads origin zero, normal +z,
// tolerance zero. A stalled output parks one result in a skid register; only then
// does o_in_ready drop, and the whole pipe holds until the skid drains.
module segment_plane_intersect
    import spi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_seg_req             i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_seg_rsp             o_out_rsp,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgW-1:0]      i_cfg_data
);

    localparam int DifW = CoordW + 1;         // point minus origin
    localparam int PrdW = DifW + NrmW;        // one term of the dot product
    localparam int SumW = PrdW + 2;           // sum of three terms
    localparam int HgtW = SumW - NrmFrac;     // height in coordinate format
    localparam int CmpW = HgtW + 1;           // height against tolerance
    localparam int DenW = HgtW + 1;           // |hs| + |he|
    localparam int RemW = DenW + 2;           // partial remainder, below 3 * den
    localparam int HitW = CoordW + 2;         // start plus signed offset

    typedef struct packed {
        logic intersects;
        logic crossing;
        logic below;
        logic above;
        logic upwards;
        logic downwards;
        logic start_touch;
        logic end_touch;
        logic coincident;
    } t_flg;

    typedef struct packed {
        t_flg                         flg;
        logic [2:0][CoordW-1:0]       base;   // start, touching end, or zero
        logic [2:0]                   dneg;   // end - start is negative
        logic [2:0][CoordW-1:0]       dmag;   // |end - start|
        logic [DenW-1:0]              ah;     // |start height|
        logic [DenW-1:0]              den;
    } t_cy;

    // Plane registers
    logic signed [OrgW-1:0] r_org [3];
    logic signed [NrmW-1:0] r_nrm [3];
    logic        [TolW-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NrmZReset;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORG_X: r_org[0] <= i_cfg_data[OrgW-1:0];
                CFG_ORG_Y: r_org[1] <= i_cfg_data[OrgW-1:0];
                CFG_ORG_Z: r_org[2] <= i_cfg_data[OrgW-1:0];
                CFG_NRM_X: r_nrm[0] <= i_cfg_data[NrmW-1:0];
                CFG_NRM_Y: r_nrm[1] <= i_cfg_data[NrmW-1:0];
                CFG_NRM_Z: r_nrm[2] <= i_cfg_data[NrmW-1:0];
                CFG_TOL:   r_tol    <= i_cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    // Pipe advance: everything moves unless a result sits in the skid register
    logic r_svld;
    logic en;
    assign en         = !r_svld;
    assign o_in_ready = en;

    // Stage 1: offsets from the plane origin, and the segment ends
    logic                     r1_v;
    logic signed [DifW-1:0]   r1_dps [3];
    logic signed [DifW-1:0]   r1_dpe [3];
    logic [2:0][CoordW-1:0]   r1_s;
    logic [2:0][CoordW-1:0]   r1_e;
    logic [2:0][CoordW-1:0]   n_s;
    logic [2:0][CoordW-1:0]   n_e;

    assign n_s = {i_in_req.seg_start_z, i_in_req.seg_start_y, i_in_req.seg_start_x};
    assign n_e = {i_in_req.seg_end_z, i_in_req.seg_end_y, i_in_req.seg_end_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_dps[i] <= {n_s[i][CoordW-1], n_s[i]} - {r_org[i][OrgW-1], r_org[i]};
                r1_dpe[i] <= {n_e[i][CoordW-1], n_e[i]} - {r_org[i][OrgW-1], r_org[i]};
            end
            r1_s <= n_s;
            r1_e <= n_e;
        end
    end

    // Stage 2: products with the normal
    logic                     r2_v;
    logic signed [PrdW-1:0]   r2_ps [3];
    logic signed [PrdW-1:0]   r2_pe [3];
    logic [2:0][CoordW-1:0]   r2_s;
    logic [2:0][CoordW-1:0]   r2_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_ps[i] <= r1_dps[i] * r_nrm[i];
                r2_pe[i] <= r1_dpe[i] * r_nrm[i];
            end
            r2_s <= r1_s;
            r2_e <= r1_e;
        end
    end

    // Stage 3: heights, floored to the coordinate format
    logic                     r3_v;
    logic signed [HgtW-1:0]   r3_hs;
    logic signed [HgtW-1:0]   r3_he;
    logic [2:0][CoordW-1:0]   r3_s;
    logic [2:0][CoordW-1:0]   r3_e;
    logic signed [SumW-1:0]   n_sums;
    logic signed [SumW-1:0]   n_sume;

    assign n_sums = SumW'(r2_ps[0]) + SumW'(r2_ps[1]) + SumW'(r2_ps[2]);
    assign n_sume = SumW'(r2_pe[0]) + SumW'(r2_pe[1]) + SumW'(r2_pe[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_hs <= HgtW'(n_sums >>> NrmFrac);
            r3_he <= HgtW'(n_sume >>> NrmFrac);
            r3_s  <= r2_s;
            r3_e  <= r2_e;
        end
    end

    // Stage 4: classify both ends, pick flags and base point
    logic signed [CmpW-1:0]   n_hsc;
    logic signed [CmpW-1:0]   n_hec;
    logic signed [CmpW-1:0]   n_tolc;
    logic                     n_sbel, n_sabv, n_ebel, n_eabv, n_son, n_eon;
    logic signed [DenW-1:0]   n_hsw;
    logic signed [DenW-1:0]   n_hew;
    logic [DenW-1:0]          n_ahs;
    logic [DenW-1:0]          n_ahe;
    t_cy                      n_cy0;
    logic signed [DifW-1:0]   n_d [3];

    assign n_hsc  = CmpW'(r3_hs);
    assign n_hec  = CmpW'(r3_he);
    assign n_tolc = $signed({(CmpW - TolW)'(0), r_tol});
    assign n_sbel = n_hsc < -n_tolc;
    assign n_sabv = n_hsc > n_tolc;
    assign n_ebel = n_hec < -n_tolc;
    assign n_eabv = n_hec > n_tolc;
    assign n_son  = !n_sbel && !n_sabv;
    assign n_eon  = !n_ebel && !n_eabv;
    assign n_hsw  = DenW'(r3_hs);
    assign n_hew  = DenW'(r3_he);
    assign n_ahs  = n_hsw[DenW-1] ? DenW'(-n_hsw) : DenW'(n_hsw);
    assign n_ahe  = n_hew[DenW-1] ? DenW'(-n_hew) : DenW'(n_hew);

    always_comb begin
        n_cy0      = '0;
        n_cy0.ah   = n_ahs;
        n_cy0.den  = n_ahs + n_ahe;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = {r3_e[i][CoordW-1], r3_e[i]} - {r3_s[i][CoordW-1], r3_s[i]};
            n_cy0.dneg[i] = n_d[i][DifW-1];
            n_cy0.dmag[i] = n_d[i][DifW-1] ? CoordW'(-n_d[i]) : CoordW'(n_d[i]);
        end
        priority if (n_sbel && n_ebel) begin
            n_cy0.flg.below = 1'b1;
        end else if (n_sabv && n_eabv) begin
            n_cy0.flg.above = 1'b1;
        end else if ((n_sbel && n_eabv) || (n_sabv && n_ebel)) begin
            n_cy0.flg.intersects = 1'b1;
            n_cy0.flg.crossing   = 1'b1;
            n_cy0.flg.upwards    = n_sbel;
            n_cy0.flg.downwards  = n_sabv;
            n_cy0.base           = r3_s;
        end else if (!n_son) begin
            // start off the plane, end touching it
            n_cy0.flg.intersects = 1'b1;
            n_cy0.flg.end_touch  = 1'b1;
            n_cy0.flg.below      = n_sbel;
            n_cy0.flg.above      = n_sabv;
            n_cy0.flg.upwards    = n_sbel;
            n_cy0.flg.downwards  = n_sabv;
            n_cy0.base           = r3_e;
        end else if (!n_eon) begin
            n_cy0.flg.intersects  = 1'b1;
            n_cy0.flg.start_touch = 1'b1;
            n_cy0.flg.below       = n_ebel;
            n_cy0.flg.above       = n_eabv;
            n_cy0.flg.downwards   = n_ebel;
            n_cy0.flg.upwards     = n_eabv;
            n_cy0.base            = r3_s;
        end else begin
            n_cy0.flg.intersects = 1'b1;
            n_cy0.flg.coincident = 1'b1;
        end
    end

    // Interpolation: stage k folds in bit CoordW-1-k of |d|, keeping
    // q * den + rem == prefix(|d|) * ah with rem below den.
    logic                  r_vl [0:CoordW];
    t_cy                   r_cy [0:CoordW];
    logic [RemW-1:0]       r_rm [0:CoordW][0:2];
    logic [CoordW-1:0]     r_q  [0:CoordW][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl[0] <= 1'b0;
        end else if (en) begin
            r_vl[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cy[0] <= n_cy0;
            for (int l = 0; l < 3; l++) begin
                r_rm[0][l] <= '0;
                r_q[0][l]  <= '0;
            end
        end
    end

    for (genvar k = 0; k < CoordW; k++) begin : g_div
        logic [RemW-1:0]   n_rm [3];
        logic [CoordW-1:0] n_q  [3];

        always_comb begin
            logic [RemW-1:0] sum2;
            logic [RemW-1:0] den1;
            logic [RemW-1:0] den2;
            den1 = RemW'(r_cy[k].den);
            den2 = {den1[RemW-2:0], 1'b0};
            for (int l = 0; l < 3; l++) begin
                sum2 = {r_rm[k][l][RemW-2:0], 1'b0}
                     + (r_cy[k].dmag[l][CoordW-1-k] ? RemW'(r_cy[k].ah) : '0);
                priority if (sum2 >= den2) begin
                    n_rm[l] = sum2 - den2;
                    n_q[l]  = {r_q[k][l][CoordW-2:0], 1'b0} + CoordW'(2);
                end else if (sum2 >= den1) begin
                    n_rm[l] = sum2 - den1;
                    n_q[l]  = {r_q[k][l][CoordW-2:0], 1'b1};
                end else begin
                    n_rm[l] = sum2;
                    n_q[l]  = {r_q[k][l][CoordW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl[k+1] <= 1'b0;
            end else if (en) begin
                r_vl[k+1] <= r_vl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cy[k+1] <= r_cy[k];
                for (int l = 0; l < 3; l++) begin
                    r_rm[k+1][l] <= n_rm[l];
                    r_q[k+1][l]  <= n_q[l];
                end
            end
        end
    end

    // Final: apply the signed offset for a crossing, saturate, assemble result
    t_seg_rsp                n_rsp;
    logic [2:0][CoordW-1:0]  n_hit;

    always_comb begin
        logic signed [HitW-1:0] bse;
        logic signed [HitW-1:0] qx;
        logic signed [HitW-1:0] tot;
        for (int l = 0; l < 3; l++) begin
            bse = HitW'($signed(r_cy[CoordW].base[l]));
            qx  = $signed({2'b00, r_q[CoordW][l]});
            tot = r_cy[CoordW].dneg[l] ? bse - qx : bse + qx;
            if (!r_cy[CoordW].flg.crossing) begin
                n_hit[l] = r_cy[CoordW].base[l];
            end else if (tot[HitW-1] && !(&tot[HitW-2:CoordW-1])) begin
                n_hit[l] = {1'b1, (CoordW-1)'(0)};
            end else if (!tot[HitW-1] && (|tot[HitW-2:CoordW-1])) begin
                n_hit[l] = {1'b0, {(CoordW-1){1'b1}}};
            end else begin
                n_hit[l] = tot[CoordW-1:0];
            end
        end
        n_rsp.intersects  = r_cy[CoordW].flg.intersects;
        n_rsp.crossing    = r_cy[CoordW].flg.crossing;
        n_rsp.below       = r_cy[CoordW].flg.below;
        n_rsp.above       = r_cy[CoordW].flg.above;
        n_rsp.upwards     = r_cy[CoordW].flg.upwards;
        n_rsp.downwards   = r_cy[CoordW].flg.downwards;
        n_rsp.start_touch = r_cy[CoordW].flg.start_touch;
        n_rsp.end_touch   = r_cy[CoordW].flg.end_touch;
        n_rsp.coincident  = r_cy[CoordW].flg.coincident;
        n_rsp.hit_x       = n_hit[0];
        n_rsp.hit_y       = n_hit[1];
        n_rsp.hit_z       = n_hit[2];
    end

    // Output register with one skid entry behind it
    logic     r_ovld;
    t_seg_rsp r_orsp;
    t_seg_rsp r_srsp;
    logic     out_free;
    logic     push;

    assign out_free = !r_ovld || i_out_ready;
    assign push     = en && r_vl[CoordW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (out_free) begin
            if (r_svld) begin
                r_ovld <= 1'b1;
                r_svld <= 1'b0;
            end else begin
                r_ovld <= push;
            end
        end else if (push) begin
            r_svld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_orsp <= r_svld ? r_srsp : n_rsp;
        end else if (push) begin
            r_srsp <= n_rsp;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_rsp   = r_orsp;

endmodule

### rtl/spi_chk.sv
`include "assert_macros.svh"

module spi_chk
    import spi_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_seg_rsp o_out_rsp
);

    `SPI_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid,
        "result dropped while stalled")
    `SPI_ASSERT_NOW(a_cross_int, o_out_valid && o_out_rsp.crossing,
        o_out_rsp.intersects && (o_out_rsp.upwards != o_out_rsp.downwards),
        "crossing without direction")
    `SPI_ASSERT_NOW(a_side_excl, o_out_valid, !(o_out_rsp.below && o_out_rsp.above),
        "below and above together")
    `SPI_ASSERT_NOW(a_no_hit_zero,
        o_out_valid && (!o_out_rsp.intersects || o_out_rsp.coincident),
        o_out_rsp.hit_x == '0 && o_out_rsp.hit_y == '0 && o_out_rsp.hit_z == '0,
        "point not zero")

endmodule

bind segment_plane_intersect spi_chk u_spi_chk (.*);

### tb/spi_result_checker.sv
`timescale 1ns / 100ps

module spi_result_checker
    import spi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_seg_req             i_in_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_seg_rsp             i_out_rsp,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgW-1:0]      i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_crossings
);

    typedef enum logic [1:0] {SIDE_BELOW, SIDE_ON, SIDE_ABOVE} t_side;

    logic signed [OrgW-1:0] org_x, org_y, org_z;
    logic signed [NrmW-1:0] nrm_x, nrm_y, nrm_z;
    logic        [TolW-1:0] tol;
    t_seg_rsp               hits_due[$];

    function automatic longint plane_height(logic signed [CoordW-1:0] px,
                                            logic signed [CoordW-1:0] py,
                                            logic signed [CoordW-1:0] pz);
        longint acc;
        acc = (longint'(px) - longint'(org_x)) * longint'(nrm_x)
            + (longint'(py) - longint'(org_y)) * longint'(nrm_y)
            + (longint'(pz) - longint'(org_z)) * longint'(nrm_z);
        return acc >>> NrmFrac;
    endfunction

    function automatic t_side side_of(longint h);
        longint band;
        band = longint'({1'b0, tol});
        if (h < -band) return SIDE_BELOW;
        if (h > band)  return SIDE_ABOVE;
        return SIDE_ON;
    endfunction

    // Offset from the start truncated toward zero, then clamped to the coordinate range.
    function automatic logic signed [CoordW-1:0] lerp_coord(logic signed [CoordW-1:0] s,
                                                             logic signed [CoordW-1:0] e,
                                                             logic [127:0] ah,
                                                             logic [127:0] den);
        longint      d, v;
        logic [127:0] dmag, q;
        d    = longint'(e) - longint'(s);
        dmag = (d < 0) ? 128'(-d) : 128'(d);
        q    = (dmag * ah) / den;
        v    = (d < 0) ? longint'(s) - longint'(q[63:0]) : longint'(s) + longint'(q[63:0]);
        if (v > 64'sd2147483647)  v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[CoordW-1:0];
    endfunction

    function automatic t_seg_rsp predict_hit(t_seg_req r);
        t_seg_rsp     p;
        longint       hs, he;
        t_side        cs, ce;
        logic [127:0] ah, den;
        p  = '0;
        hs = plane_height(r.seg_start_x, r.seg_start_y, r.seg_start_z);
        he = plane_height(r.seg_end_x, r.seg_end_y, r.seg_end_z);
        cs = side_of(hs);
        ce = side_of(he);
        if (cs != SIDE_ON && ce == cs) begin
            p.below = (cs == SIDE_BELOW);
            p.above = (cs == SIDE_ABOVE);
        end else if (cs != SIDE_ON && ce != SIDE_ON) begin
            ah  = (hs < 0) ? 128'(-hs) : 128'(hs);
            den = ah + ((he < 0) ? 128'(-he) : 128'(he));
            p.intersects = 1'b1;
            p.crossing   = 1'b1;
            p.upwards    = (cs == SIDE_BELOW);
            p.downwards  = (cs == SIDE_ABOVE);
            p.hit_x = lerp_coord(r.seg_start_x, r.seg_end_x, ah, den);
            p.hit_y = lerp_coord(r.seg_start_y, r.seg_end_y, ah, den);
            p.hit_z = lerp_coord(r.seg_start_z, r.seg_end_z, ah, den);
        end else if (cs != SIDE_ON) begin
            p.intersects = 1'b1;
            p.end_touch  = 1'b1;
            p.below      = (cs == SIDE_BELOW);
            p.above      = (cs == SIDE_ABOVE);
            p.upwards    = (cs == SIDE_BELOW);
            p.downwards  = (cs == SIDE_ABOVE);
            p.hit_x = r.seg_end_x;
            p.hit_y = r.seg_end_y;
            p.hit_z = r.seg_end_z;
        end else if (ce != SIDE_ON) begin
            p.intersects  = 1'b1;
            p.start_touch = 1'b1;
            p.below       = (ce == SIDE_BELOW);
            p.above       = (ce == SIDE_ABOVE);
            p.downwards   = (ce == SIDE_BELOW);
            p.upwards     = (ce == SIDE_ABOVE);
            p.hit_x = r.seg_start_x;
            p.hit_y = r.seg_start_y;
            p.hit_z = r.seg_start_z;
        end else begin
            p.intersects = 1'b1;
            p.coincident = 1'b1;
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
        o_fail_count++;
    endtask

    task automatic compare_hit(t_seg_rsp got, t_seg_rsp want);
        if (got.intersects !== want.intersects)
            report_mismatch("intersects", 64'(got.intersects), 64'(want.intersects));
        if (got.crossing !== want.crossing)
            report_mismatch("crossing", 64'(got.crossing), 64'(want.crossing));
        if (got.below !== want.below)
            report_mismatch("below", 64'(got.below), 64'(want.below));
        if (got.above !== want.above)
            report_mismatch("above", 64'(got.above), 64'(want.above));
        if (got.upwards !== want.upwards)
            report_mismatch("upwards", 64'(got.upwards), 64'(want.upwards));
        if (got.downwards !== want.downwards)
            report_mismatch("downwards", 64'(got.downwards), 64'(want.downwards));
        if (got.start_touch !== want.start_touch)
            report_mismatch("start_touch", 64'(got.start_touch), 64'(want.start_touch));
        if (got.end_touch !== want.end_touch)
            report_mismatch("end_touch", 64'(got.end_touch), 64'(want.end_touch));
        if (got.coincident !== want.coincident)
            report_mismatch("coincident", 64'(got.coincident), 64'(want.coincident));
        if (got.hit_x !== want.hit_x)
            report_mismatch("hit_x", 64'(got.hit_x), 64'(want.hit_x));
        if (got.hit_y !== want.hit_y)
            report_mismatch("hit_y", 64'(got.hit_y), 64'(want.hit_y));
        if (got.hit_z !== want.hit_z)
            report_mismatch("hit_z", 64'(got.hit_z), 64'(want.hit_z));
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_crossings  = 0;
    end

    assign o_pending = hits_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
            nrm_x <= '0;
            nrm_y <= '0;
            nrm_z <= NrmZReset;
            tol   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORG_X: org_x <= i_cfg_data[OrgW-1:0];
                    CFG_ORG_Y: org_y <= i_cfg_data[OrgW-1:0];
                    CFG_ORG_Z: org_z <= i_cfg_data[OrgW-1:0];
                    CFG_NRM_X: nrm_x <= i_cfg_data[NrmW-1:0];
                    CFG_NRM_Y: nrm_y <= i_cfg_data[NrmW-1:0];
                    CFG_NRM_Z: nrm_z <= i_cfg_data[NrmW-1:0];
                    CFG_TOL:   tol   <= i_cfg_data[TolW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                hits_due.push_back(predict_hit(i_in_req));
            if (i_out_valid && i_out_ready) begin
                if (hits_due.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    compare_hit(i_out_rsp, hits_due.pop_front());
                    o_checked++;
                    if (i_out_rsp.crossing) o_crossings++;
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spi_pkg::*;

    localparam int PhaseItems = 317;
    localparam int Drain      = CoordW + 20;     // pipeline depth plus margin
    localparam int CycleLimit = 400000;
    // Index past the last register: the block must ignore writes to it.
    localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_seg_req           in_req;
    logic               out_valid;
    logic               out_ready;
    t_seg_rsp           out_rsp;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [CfgW-1:0]    cfg_data;

    int fail_count, pending, checked, crossings;
    int snd_idle_pct, rcv_idle_pct;
    int cycles, sent;
    logic signed [CoordW-1:0] org_x, org_y, org_z;   // current plane origin, for near-plane points

    segment_plane_intersect dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    spi_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (out_rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_crossings  (crossings)
    );

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Stall the result side at the rate of the current phase.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: end the run if the block stops moving.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[segment_plane_intersect] ERROR");
            $finish;
        end
    end

    function automatic t_seg_req seg(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                     logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        t_seg_req r;
        r.seg_start_x = sx;
        r.seg_start_y = sy;
        r.seg_start_z = sz;
        r.seg_end_x   = ex;
        r.seg_end_y   = ey;
        r.seg_end_z   = ez;
        return r;
    endfunction

    // Fully random coordinate, or one close to the origin so it lands near the plane.
    function automatic logic [31:0] pick_coord(logic [31:0] centre, bit near);
        int k;
        logic [31:0] off;
        if (!near) return $urandom;
        k   = $urandom_range(24, 2);
        off = $urandom_range((1 << k) - 1);
        if ($urandom_range(1)) off = -off;
        return centre + off;
    endfunction

    function automatic t_seg_req random_seg();
        t_seg_req r;
        bit near_s, near_e;
        near_s = ($urandom_range(3) != 0);
        near_e = ($urandom_range(3) != 0);
        r.seg_start_x = pick_coord(org_x, near_s);
        r.seg_start_y = pick_coord(org_y, near_s);
        r.seg_start_z = pick_coord(org_z, near_s);
        r.seg_end_x   = pick_coord(org_x, near_e);
        r.seg_end_y   = pick_coord(org_y, near_e);
        r.seg_end_z   = pick_coord(org_z, near_e);
        // Zero-length segments now and then.
        if ($urandom_range(19) == 0) begin
            r.seg_end_x = r.seg_start_x;
            r.seg_end_y = r.seg_start_y;
            r.seg_end_z = r.seg_start_z;
        end
        return r;
    endfunction

    // Hold the request until accepted; idle before it at the sender's rate.
    task automatic send_seg(t_seg_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_plane(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                              logic [31:0] band);
        write_reg(CFG_ORG_X, ox);
        write_reg(CFG_ORG_Y, oy);
        write_reg(CFG_ORG_Z, oz);
        write_reg(CFG_NRM_X, nx);
        write_reg(CFG_NRM_Y, ny);
        write_reg(CFG_NRM_Z, nz);
        write_reg(CFG_TOL, band);
        cfg_we <= 1'b0;
        org_x = ox;
        org_y = oy;
        org_z = oz;
    endtask

    // Drop valid, wait for every result, then let the pipe empty.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (Drain) @(posedge clk);
    endtask

    task automatic random_phase(int snd, int rcv);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        repeat (PhaseItems) send_seg(random_seg());
        drain_pipe();
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        cycles       = 0;
        sent         = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        org_x        = '0;
        org_y        = '0;
        org_z        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset plane is z = 0 with no band: height equals z.
        send_seg(seg(0, 0, -5, 0, 0, -7));                        // both below
        send_seg(seg(0, 0, 9, 0, 0, 3));                          // both above
        send_seg(seg(32'h8000_0000, 0, -1, 32'h7fff_ffff, 5, 3)); // crossing upward
        send_seg(seg(10, 20, 40, -10, -20, -60));                 // crossing downward
        send_seg(seg(1, 2, -4, 3, 4, 0));                         // below, touch at end
        send_seg(seg(1, 2, 4, 3, 4, 0));                          // above, touch at end
        send_seg(seg(7, 8, 0, 3, 4, -9));                         // touch at start, then below
        send_seg(seg(7, 8, 0, 3, 4, 9));                          // touch at start, then above
        send_seg(seg(7, 8, 0, 3, 4, 0));                          // lies in the plane
        send_seg(seg('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1));
        send_seg(seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_seg(seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_seg(seg(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        drain_pipe();

        // Band edges: +-100 counts as on the plane, 101 does not.
        write_reg(CFG_TOL, 100);
        write_reg(CfgUnused, 32'hdead_beef);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_seg(seg(0, 0, 100, 0, 0, 101));
        send_seg(seg(0, 0, -100, 0, 0, -101));
        send_seg(seg(0, 0, 101, 0, 0, -101));
        send_seg(seg(0, 0, 100, 0, 0, -100));
        drain_pipe();

        // Tilted plane, random origin, moderate band.
        load_plane($urandom, $urandom, $urandom,
                   $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                   $urandom_range(32768) - 16384, 32'h0010_0000);
        random_phase(33, 86);

        // Extremes: corner origin, full-scale normal with junk upper bits, widest band
        // with bit 31 set so only the low 31 bits may count.
        load_plane(32'h8000_0000, 32'h7fff_ffff, 0,
                   32'hffff_c000, 32'h0000_4000, 32'h1234_8000, 32'hffff_ffff);
        random_phase(86, 33);

        // Axis normal, no band.
        load_plane($urandom, $urandom, $urandom, 0, 0, 32'h0000_4000, 0);
        random_phase(0, 0);

        $display("sent %0d segments over five plane settings", sent);
        $display("checked %0d results, %0d of them crossings", checked, crossings);
        if (fail_count == 0) begin
            $display("[segment_plane_intersect] OK");
        end else begin
            $display("[segment_plane_intersect] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/spi_pkg.sv
rtl/segment_plane_intersect.sv
rtl/spi_chk.sv
tb/spi_result_checker.sv
tb/tb_top.sv
